// ===== src/wfc_pkg.sv =====
`timescale 1ns / 1ps
package wfc_pkg;

    localparam int QUEUE_DEPTH_DEF  = 64;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam int DIFF_W   = 17;
    localparam int CORDIC_W = 28;
    localparam int ZACC_W   = 25;
    localparam int MUL_W    = 18;
    localparam int PROD_W   = 2 * MUL_W;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_POSE   = 2'd2;
    localparam logic [1:0] CMD_STOP   = 2'd3;

    localparam logic [1:0] CFG_SPEED_GAIN = 2'd0;
    localparam logic [1:0] CFG_TURN_GAIN  = 2'd1;
    localparam logic [1:0] CFG_ARRIVE_RAD = 2'd2;
    localparam logic [1:0] CFG_HEAD_TOL   = 2'd3;

    localparam logic [15:0] SPEED_GAIN_RST = 16'd3277;
    localparam logic [15:0] TURN_GAIN_RST  = 16'd13107;
    localparam logic [14:0] ARRIVE_RAD_RST = 15'd154;
    localparam logic [14:0] HEAD_TOL_RST   = 15'd3641;

    typedef enum logic [2:0] {
        MUL_DX2,
        MUL_DY2,
        MUL_R2,
        MUL_SPEED,
        MUL_TURN
    } mul_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     do_begin;
        logic     do_push;
        logic     do_stop;
        logic     do_zero;
        logic     do_align;
        logic     diff_first;
        logic     diff_head;
        logic     cordic_init;
        logic     cordic_load;
        logic     cordic_step;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     near_load;
        logic     alpha_wr;
        logic     speed_wr;
        logic     turn_wr;
        logic     head_wr;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       count_one;
        logic       full;
        logic       route_starting;
        logic       in_tol;
        logic       cordic_last;
    } dp_status_t;

    function automatic logic [22:0] atan_entry(input logic [4:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:    v = 23'd2097152;
            5'd1:    v = 23'd1238021;
            5'd2:    v = 23'd654136;
            5'd3:    v = 23'd332050;
            5'd4:    v = 23'd166669;
            5'd5:    v = 23'd83416;
            5'd6:    v = 23'd41718;
            5'd7:    v = 23'd20860;
            5'd8:    v = 23'd10430;
            5'd9:    v = 23'd5215;
            5'd10:   v = 23'd2608;
            5'd11:   v = 23'd1304;
            5'd12:   v = 23'd652;
            5'd13:   v = 23'd326;
            5'd14:   v = 23'd163;
            5'd15:   v = 23'd81;
            5'd16:   v = 23'd41;
            5'd17:   v = 23'd20;
            5'd18:   v = 23'd10;
            5'd19:   v = 23'd5;
            5'd20:   v = 23'd3;
            5'd21:   v = 23'd1;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/wfc_ram.sv =====
`timescale 1ns / 1ps
module wfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/wfc_datapath.sv =====
`timescale 1ns / 1ps
module wfc_datapath
    import wfc_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_cmd_t  ctl,
    output dp_status_t st,
    input  logic [55:0] s_tdata,
    output logic [39:0] m_tdata,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic [15:0] speed_gain_reg, turn_gain_reg;
    logic [14:0] arrive_rad_reg, head_tol_reg;

    logic [1:0]  cmd_reg;
    logic [15:0] px_reg, py_reg, hd_reg;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rs_reg, rs_next;
    logic [15:0]      start_hd_reg, start_hd_next;
    logic [31:0]      first_reg, first_next;
    logic [15:0]      speed_reg, speed_next;
    logic [15:0]      turn_reg, turn_next;

    logic signed [DIFF_W-1:0]   dx_reg, dy_reg;
    logic signed [CORDIC_W-1:0] cx_reg, cy_reg;
    logic signed [ZACC_W-1:0]   cz_reg;
    logic                       neg_reg, zero_reg;
    logic [STEP_W-1:0]          step_reg;
    logic signed [15:0]         ang_reg;
    logic signed [PROD_W-1:0]   prod_reg, acc_reg;
    logic                       near_reg;
    logic [33:0]                out_reg;

    logic [31:0]      ram_rdata;
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [31:0]      wp;
    logic [CNT_W:0]   push_sum;
    logic             pop;
    logic             full;

    logic signed [15:0] err;
    logic signed [16:0] err_ext, err_mag, ang_ext, ang_mag;
    logic signed [DIFF_W-1:0] dxn, dyn;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic signed [ZACC_W-1:0] tab, zr;
    logic [15:0] atan16;
    logic signed [MUL_W-1:0] ma, mb;

    assign wp   = {py_reg, px_reg};
    assign full = count_reg == CNT_W'(QUEUE_DEPTH);

    assign push_sum  = {1'b0, {(CNT_W - PTR_W){1'b0}}, head_reg} + {1'b0, count_reg};
    assign ram_waddr = (push_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                       ? PTR_W'(push_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                       : PTR_W'(push_sum);
    assign ram_we    = ctl.do_begin || (ctl.do_push && !full);

    wfc_ram #(
        .WIDTH (32),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ctl.do_begin ? '0 : ram_waddr),
        .wdata (wp),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign err     = $signed(start_hd_reg - hd_reg);
    assign err_ext = {err[15], err};
    assign err_mag = err_ext[16] ? -err_ext : err_ext;
    assign ang_ext = {ang_reg[15], ang_reg};
    assign ang_mag = ang_ext[16] ? -ang_ext : ang_ext;

    assign st.cmd            = cmd_reg;
    assign st.count_zero     = count_reg == '0;
    assign st.count_one      = count_reg == CNT_W'(1);
    assign st.full           = full;
    assign st.route_starting = rs_reg;
    assign st.in_tol         = err_mag < $signed({2'b00, head_tol_reg});
    assign st.cordic_last    = step_reg == STEP_W'(CORDIC_STEPS - 1);

    assign pop = (ctl.do_align && st.in_tol) || (ctl.turn_wr && near_reg);

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        rs_next       = rs_reg;
        start_hd_next = start_hd_reg;
        first_next    = first_reg;
        speed_next    = speed_reg;
        turn_next     = turn_reg;
        if (ctl.do_begin)
        begin
            head_next     = '0;
            count_next    = CNT_W'(1);
            first_next    = wp;
            start_hd_next = '0;
            rs_next       = 1'b1;
        end
        if (ctl.do_push && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctl.do_stop)
        begin
            head_next  = '0;
            count_next = '0;
            rs_next    = 1'b0;
            speed_next = '0;
            turn_next  = '0;
        end
        if (ctl.do_zero)
        begin
            speed_next = '0;
            turn_next  = '0;
        end
        if (ctl.do_align)
        begin
            if (st.in_tol)
            begin
                rs_next = 1'b0;
            end
            else
            begin
                speed_next = '0;
            end
        end
        if (ctl.head_wr)
        begin
            start_hd_next = zero_reg ? 16'd0 : atan16;
        end
        if (ctl.speed_wr)
        begin
            speed_next = prod_reg[30:15];
        end
        if (ctl.turn_wr)
        begin
            turn_next = prod_reg[31:16];
        end
        if (pop && count_reg != '0)
        begin
            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                speed_next = '0;
                turn_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            rs_reg         <= 1'b0;
            start_hd_reg   <= '0;
            first_reg      <= '0;
            speed_reg      <= '0;
            turn_reg       <= '0;
            speed_gain_reg <= SPEED_GAIN_RST;
            turn_gain_reg  <= TURN_GAIN_RST;
            arrive_rad_reg <= ARRIVE_RAD_RST;
            head_tol_reg   <= HEAD_TOL_RST;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            rs_reg       <= rs_next;
            start_hd_reg <= start_hd_next;
            first_reg    <= first_next;
            speed_reg    <= speed_next;
            turn_reg     <= turn_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SPEED_GAIN: speed_gain_reg <= cfg_data;
                    CFG_TURN_GAIN:  turn_gain_reg  <= cfg_data;
                    CFG_ARRIVE_RAD: arrive_rad_reg <= cfg_data[14:0];
                    CFG_HEAD_TOL:   head_tol_reg   <= cfg_data[14:0];
                endcase
            end
        end
    end

    assign dxn = neg_reg ? -dx_reg : dx_reg;
    assign dyn = neg_reg ? -dy_reg : dy_reg;
    assign xs  = cx_reg >>> step_reg;
    assign ys  = cy_reg >>> step_reg;
    assign tab = ZACC_W'(atan_entry(5'(step_reg)));
    assign zr  = (cz_reg + ZACC_W'(128)) >>> 8;
    assign atan16 = (neg_reg ? 16'h8000 : 16'h0000) + zr[15:0];

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (ctl.mul_sel)
            MUL_DX2:
            begin
                ma = MUL_W'(dx_reg);
                mb = MUL_W'(dx_reg);
            end
            MUL_DY2:
            begin
                ma = MUL_W'(dy_reg);
                mb = MUL_W'(dy_reg);
            end
            MUL_R2:
            begin
                ma = $signed({3'b000, arrive_rad_reg});
                mb = $signed({3'b000, arrive_rad_reg});
            end
            MUL_SPEED:
            begin
                ma = $signed({2'b00, speed_gain_reg});
                mb = $signed({1'b0, 17'(17'sd32768 - ang_mag)});
            end
            MUL_TURN:
            begin
                ma = $signed({2'b00, turn_gain_reg});
                mb = MUL_W'(ang_reg);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        if (ctl.load_item)
        begin
            cmd_reg <= s_tdata[1:0];
            px_reg  <= s_tdata[17:2];
            py_reg  <= s_tdata[33:18];
            hd_reg  <= s_tdata[49:34];
        end
        if (ctl.diff_first)
        begin
            dx_reg <= $signed({px_reg[15], px_reg}) - $signed({first_reg[15], first_reg[15:0]});
            dy_reg <= $signed({py_reg[15], py_reg})
                      - $signed({first_reg[31], first_reg[31:16]});
        end
        if (ctl.diff_head)
        begin
            dx_reg <= $signed({ram_rdata[15], ram_rdata[15:0]}) - $signed({px_reg[15], px_reg});
            dy_reg <= $signed({ram_rdata[31], ram_rdata[31:16]})
                      - $signed({py_reg[15], py_reg});
        end
        if (ctl.cordic_init)
        begin
            neg_reg  <= dx_reg[DIFF_W-1];
            zero_reg <= (dx_reg == '0) && (dy_reg == '0);
            step_reg <= '0;
            cz_reg   <= '0;
        end
        if (ctl.cordic_load)
        begin
            cx_reg <= {{(CORDIC_W - DIFF_W - 8){dxn[DIFF_W-1]}}, dxn, 8'b0};
            cy_reg <= {{(CORDIC_W - DIFF_W - 8){dyn[DIFF_W-1]}}, dyn, 8'b0};
        end
        if (ctl.cordic_step)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + tab;
            end
            else
            begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - tab;
            end
        end
        if (ctl.do_align)
        begin
            ang_reg  <= err;
            near_reg <= 1'b0;
        end
        if (ctl.alpha_wr)
        begin
            ang_reg <= $signed((zero_reg ? 16'd0 : atan16) - hd_reg);
        end
        if (ctl.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (ctl.near_load)
        begin
            near_reg <= acc_reg < prod_reg;
        end
        if (ctl.out_load)
        begin
            out_reg <= {rs_reg, count_reg != '0, turn_reg, speed_reg};
        end
    end

    assign m_tdata = {6'b0, out_reg};

endmodule

// ===== src/wfc_ctrl.sv =====
`timescale 1ns / 1ps
module wfc_ctrl
    import wfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t st,
    output ctrl_cmd_t  ctl
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_DECODE   = 14'b00000000000010,
        ST_READ     = 14'b00000000000100,
        ST_CINIT    = 14'b00000000001000,
        ST_CLOAD    = 14'b00000000010000,
        ST_CORDIC   = 14'b00000000100000,
        ST_HEAD     = 14'b00000001000000,
        ST_ALPHA    = 14'b00000010000000,
        ST_SUM1     = 14'b00000100000000,
        ST_SUM2     = 14'b00001000000000,
        ST_CMP      = 14'b00010000000000,
        ST_SPEED    = 14'b00100000000000,
        ST_TURN_MUL = 14'b01000000000000,
        ST_TURN_WR  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_wait_reg, out_wait_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE) && !out_wait_reg;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        ctl           = '0;
        ctl.mul_sel   = MUL_TURN;
        state_next    = state_reg;
        out_wait_next = out_wait_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl.load_item = s_tvalid && s_tready;
        if (out_wait_reg && out_free)
        begin
            ctl.out_load  = 1'b1;
            m_tvalid_next = 1'b1;
            out_wait_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.load_item)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next    = ST_IDLE;
                out_wait_next = 1'b1;
                unique case (st.cmd)
                    CMD_BEGIN:
                    begin
                        ctl.do_begin = 1'b1;
                    end
                    CMD_APPEND:
                    begin
                        ctl.do_push = 1'b1;
                        if (!st.full && st.route_starting && st.count_one)
                        begin
                            ctl.diff_first = 1'b1;
                            state_next     = ST_CINIT;
                            out_wait_next  = 1'b0;
                        end
                    end
                    CMD_STOP:
                    begin
                        ctl.do_stop = 1'b1;
                    end
                    CMD_POSE:
                    begin
                        if (st.count_zero)
                        begin
                            ctl.do_zero = 1'b1;
                        end
                        else if (st.route_starting)
                        begin
                            ctl.do_align = 1'b1;
                            if (!st.in_tol)
                            begin
                                state_next    = ST_TURN_MUL;
                                out_wait_next = 1'b0;
                            end
                        end
                        else
                        begin
                            state_next    = ST_READ;
                            out_wait_next = 1'b0;
                        end
                    end
                endcase
            end
            ST_READ:
            begin
                ctl.diff_head = 1'b1;
                state_next    = ST_CINIT;
            end
            ST_CINIT:
            begin
                ctl.cordic_init = 1'b1;
                state_next      = ST_CLOAD;
            end
            ST_CLOAD:
            begin
                ctl.cordic_load = 1'b1;
                state_next      = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                ctl.cordic_step = 1'b1;
                if (st.cordic_last)
                begin
                    state_next = (st.cmd == CMD_APPEND) ? ST_HEAD : ST_ALPHA;
                end
            end
            ST_HEAD:
            begin
                ctl.head_wr   = 1'b1;
                state_next    = ST_IDLE;
                out_wait_next = 1'b1;
            end
            ST_ALPHA:
            begin
                ctl.alpha_wr = 1'b1;
                ctl.mul_sel  = MUL_DX2;
                state_next   = ST_SUM1;
            end
            ST_SUM1:
            begin
                ctl.acc_load = 1'b1;
                ctl.mul_sel  = MUL_DY2;
                state_next   = ST_SUM2;
            end
            ST_SUM2:
            begin
                ctl.acc_add = 1'b1;
                ctl.mul_sel = MUL_R2;
                state_next  = ST_CMP;
            end
            ST_CMP:
            begin
                ctl.near_load = 1'b1;
                ctl.mul_sel   = MUL_SPEED;
                state_next    = ST_SPEED;
            end
            ST_SPEED:
            begin
                ctl.speed_wr = 1'b1;
                ctl.mul_sel  = MUL_TURN;
                state_next   = ST_TURN_WR;
            end
            ST_TURN_MUL:
            begin
                ctl.mul_sel = MUL_TURN;
                state_next  = ST_TURN_WR;
            end
            ST_TURN_WR:
            begin
                ctl.turn_wr   = 1'b1;
                state_next    = ST_IDLE;
                out_wait_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_wait_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_wait_reg <= out_wait_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== src/waypoint_follow_controller.sv =====
`timescale 1ns / 1ps
// Waypoint-following drive controller. Each input transfer carries a command
// (begin route, append waypoint, pose update, stop) and gives exactly one
// result transfer with speed, turn rate, route-active and aligning flags.
// Waypoints are held in a QUEUE_DEPTH-entry RAM; a full queue drops them.
// The append that sets the start heading runs the one-iteration-per-cycle
// CORDIC for bearing; a pose update that steers toward a waypoint runs that
// CORDIC followed by the single shared multiplier used for distance, speed and
// turn, and an aligning pose update short of the start heading uses the
// multiplier for turn only. One item is in work at a time; the next may enter
// while a result still waits in the output register.
module waypoint_follow_controller
    import wfc_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // command[1:0], x_pos, y_pos, heading, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // drive_speed, turn_rate, route_active, aligning, pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    ctrl_cmd_t  ctl;
    dp_status_t st;

    wfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .ctl      (ctl)
    );

    wfc_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .st        (st),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== sim/waypoint_follow_controller_tb.sv =====
`timescale 1ns / 1ps
module waypoint_follow_controller_tb;
    import wfc_pkg::*;

    localparam int DEPTH       = 64;
    localparam int STEPS       = 16;
    localparam int CYCLE_LIMIT = 800000;
    localparam int EXP_SLOTS   = 16;

    typedef struct packed {
        logic        aligning;
        logic        active;
        logic [15:0] turn;
        logic [15:0] speed;
    } drive_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // command[1:0], x_pos, y_pos, heading, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // drive_speed, turn_rate, route_active, aligning, pad
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    waypoint_follow_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller state mirror
    logic [31:0] wp_store [DEPTH];
    int          wp_head;
    int          wp_count;
    bit          mdl_aligning;
    int          mdl_start_hd;
    logic [31:0] mdl_first;
    int          mdl_speed;
    int          mdl_turn;
    int          gain_speed;
    int          gain_turn;
    int          radius;
    int          tolerance;

    drive_out_t  exp_ring [EXP_SLOTS];
    int          exp_wr_idx;
    int          exp_rd_idx;
    int          mismatches;
    int          items_sent;
    int          src_idle_pct;
    int          snk_idle_pct;
    longint      cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int wrap16(longint v);
        return int'($signed(v[15:0]));
    endfunction

    function automatic int bearing(longint dy, longint dx);
        longint x;
        longint y;
        longint z;
        longint base;
        longint xs;
        longint ys;
        z = 0;
        base = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (dx < 0)
        begin
            dx = -dx;
            dy = -dy;
            base = 32768;
        end
        x = dx * 256;
        y = dy * 256;
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(5'(i)));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(5'(i)));
            end
        end
        return wrap16(base + ((z + 128) >>> 8));
    endfunction

    function automatic int scaled_turn(int err);
        return wrap16((longint'(gain_turn) * longint'(err)) >>> 16);
    endfunction

    function automatic void pop_wp();
        if (wp_count == 0)
            return;
        wp_head = (wp_head + 1) % DEPTH;
        wp_count--;
        if (wp_count == 0)
        begin
            mdl_speed = 0;
            mdl_turn = 0;
        end
    endfunction

    function automatic void push_wp(logic [31:0] wp);
        if (wp_count >= DEPTH)
            return;
        wp_store[(wp_head + wp_count) % DEPTH] = wp;
        wp_count++;
    endfunction

    function automatic void predict_drive(logic [1:0] cmd, logic [15:0] x, logic [15:0] y,
                                          logic [15:0] h);
        int          px;
        int          py;
        int          hd;
        int          err;
        int          mag;
        logic [31:0] wp;
        logic [31:0] hwp;
        longint      dx;
        longint      dy;
        drive_out_t  r;
        px = int'($signed(x));
        py = int'($signed(y));
        hd = int'($signed(h));
        wp = {y, x};
        if (cmd == CMD_BEGIN)
        begin
            wp_head = 0;
            wp_count = 0;
            push_wp(wp);
            mdl_first = wp;
            mdl_start_hd = 0;
            mdl_aligning = 1'b1;
        end
        else if (cmd == CMD_APPEND)
        begin
            if (wp_count < DEPTH)
            begin
                if (mdl_aligning && wp_count == 1)
                begin
                    dx = longint'(px) - int'($signed(mdl_first[15:0]));
                    dy = longint'(py) - int'($signed(mdl_first[31:16]));
                    mdl_start_hd = bearing(dy, dx);
                end
                push_wp(wp);
            end
        end
        else if (cmd == CMD_STOP)
        begin
            mdl_speed = 0;
            mdl_turn = 0;
            wp_head = 0;
            wp_count = 0;
            mdl_aligning = 1'b0;
        end
        else if (wp_count == 0)
        begin
            mdl_speed = 0;
            mdl_turn = 0;
        end
        else if (mdl_aligning)
        begin
            err = wrap16(longint'(mdl_start_hd) - hd);
            mag = err < 0 ? -err : err;
            if (mag < tolerance)
            begin
                mdl_aligning = 1'b0;
                pop_wp();
            end
            else
            begin
                mdl_speed = 0;
                mdl_turn = scaled_turn(err);
            end
        end
        else
        begin
            hwp = wp_store[wp_head];
            dx = longint'(int'($signed(hwp[15:0]))) - px;
            dy = longint'(int'($signed(hwp[31:16]))) - py;
            err = wrap16(longint'(bearing(dy, dx)) - hd);
            mag = err < 0 ? -err : err;
            mdl_speed = int'((longint'(gain_speed) * (32768 - mag)) >>> 15);
            mdl_turn = scaled_turn(err);
            if (dx * dx + dy * dy < longint'(radius) * radius)
                pop_wp();
        end
        r.speed = mdl_speed[15:0];
        r.turn = mdl_turn[15:0];
        r.active = wp_count != 0;
        r.aligning = mdl_aligning;
        exp_ring[exp_wr_idx % EXP_SLOTS] = r;
        exp_wr_idx++;
    endfunction

    task automatic send_cmd(logic [1:0] cmd, int x, int y, int h);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, h[15:0], y[15:0], x[15:0], cmd};
        do
            @(posedge clk);
        while (!s_tready);
        predict_drive(cmd, x[15:0], y[15:0], h[15:0]);
        items_sent++;
    endtask

    task automatic hold_src();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        hold_src();
        wait (exp_rd_idx == exp_wr_idx);
        repeat (40) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SPEED_GAIN: gain_speed = val & 16'hFFFF;
            CFG_TURN_GAIN:  gain_turn = val & 16'hFFFF;
            CFG_ARRIVE_RAD: radius = val & 15'h7FFF;
            default:        tolerance = val & 15'h7FFF;
        endcase
    endtask

    task automatic set_gains(int sg, int tg, int ar, int ht);
        write_reg(CFG_SPEED_GAIN, sg);
        write_reg(CFG_TURN_GAIN, tg);
        write_reg(CFG_ARRIVE_RAD, ar);
        write_reg(CFG_HEAD_TOL, ht);
    endtask

    function automatic int rand_full();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int rand_near(int c, int span);
        int v;
        v = c + int'($urandom_range(2 * span)) - span;
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    task automatic test_directed();
        send_cmd(CMD_POSE, 0, 0, 0);
        send_cmd(CMD_BEGIN, 0, 0, 0);
        send_cmd(CMD_POSE, 0, 0, 16384);
        send_cmd(CMD_POSE, 0, 0, 0);
        send_cmd(CMD_POSE, 0, 0, 0);
        send_cmd(CMD_BEGIN, -32768, -32768, 0);
        send_cmd(CMD_APPEND, 32767, 32767, 0);
        send_cmd(CMD_APPEND, 0, 0, 0);
        send_cmd(CMD_POSE, 0, 0, -32768);
        send_cmd(CMD_POSE, 0, 0, 32767);
        send_cmd(CMD_POSE, 0, 0, mdl_start_hd);
        send_cmd(CMD_POSE, -32768, 32767, 32767);
        send_cmd(CMD_POSE, 32767, 32767, 0);
        send_cmd(CMD_POSE, 10, -20, -32768);
        send_cmd(CMD_POSE, 0, 0, 0);
        send_cmd(CMD_BEGIN, 100, 100, 0);
        send_cmd(CMD_APPEND, 100, 100, 0);
        send_cmd(CMD_STOP, 0, 0, 0);
        send_cmd(CMD_POSE, 5, 5, 5);
        // fill past capacity so the tail is dropped
        send_cmd(CMD_BEGIN, 0, 0, 0);
        for (int i = 0; i < DEPTH + 2; i++)
            send_cmd(CMD_APPEND, i * 50, -i * 50, 0);
        send_cmd(CMD_BEGIN, 1, 1, 0);
        send_cmd(CMD_STOP, 0, 0, 0);
        hold_src();
    endtask

    task automatic test_routes(int n_items);
        int target;
        int legs;
        int px;
        int py;
        int hx;
        int hy;
        int span;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_cmd(2'($urandom_range(3)), rand_full(), rand_full(), rand_full());
                continue;
            end
            span = $urandom_range(7) == 0 ? 32767 : 3000;
            legs = $urandom_range(1, 6);
            px = rand_near(0, span);
            py = rand_near(0, span);
            send_cmd(CMD_BEGIN, px, py, rand_full());
            for (int i = 1; i < legs; i++)
            begin
                px = rand_near(px, span);
                py = rand_near(py, span);
                send_cmd(CMD_APPEND, px, py, rand_full());
            end
            if ($urandom_range(3) == 0)
                send_cmd(CMD_POSE, rand_full(), rand_full(), rand_full());
            send_cmd(CMD_POSE, rand_full(), rand_full(),
                     rand_near(mdl_start_hd, tolerance + 200));
            for (int k = 0; k < 3 * legs + 2 && items_sent < target; k++)
            begin
                if (wp_count == 0)
                    break;
                hx = int'($signed(wp_store[wp_head][15:0]));
                hy = int'($signed(wp_store[wp_head][31:16]));
                if ($urandom_range(2) == 0)
                    send_cmd(CMD_POSE, rand_near(hx, 2000), rand_near(hy, 2000), rand_full());
                else
                    send_cmd(CMD_POSE, rand_near(hx, radius / 2 + 2),
                             rand_near(hy, radius / 2 + 2), rand_full());
            end
            if ($urandom_range(4) == 0)
                send_cmd(CMD_STOP, rand_full(), rand_full(), rand_full());
        end
        hold_src();
    endtask

    always @(posedge clk)
    begin
        m_tready <= $urandom_range(99) >= snk_idle_pct;
    end

    always @(posedge clk)
    begin
        drive_out_t got;
        drive_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[33:0];
            if (exp_rd_idx == exp_wr_idx)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %h", got);
            end
            else
            begin
                want = exp_ring[exp_rd_idx % EXP_SLOTS];
                exp_rd_idx++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: speed %0d/%0d turn %0d/%0d active %b/%b align %b/%b",
                                 want.speed, got.speed, $signed(want.turn), $signed(got.turn),
                                 want.active, got.active, want.aligning, got.aligning);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SPEED_GAIN;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        items_sent = 0;
        exp_wr_idx = 0;
        exp_rd_idx = 0;
        wp_head = 0;
        wp_count = 0;
        mdl_aligning = 1'b0;
        mdl_start_hd = 0;
        mdl_first = '0;
        mdl_speed = 0;
        mdl_turn = 0;
        gain_speed = SPEED_GAIN_RST;
        gain_turn = TURN_GAIN_RST;
        radius = ARRIVE_RAD_RST;
        tolerance = HEAD_TOL_RST;
        src_idle_pct = 15;
        snk_idle_pct = 50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_routes(250);
        set_gains(65535, 65535, 32767, 32767);
        test_directed();
        test_routes(150);
        src_idle_pct = 50;
        snk_idle_pct = 15;
        set_gains(0, 0, 0, 0);
        test_routes(150);
        set_gains(40000, 50000, 2000, 8000);
        test_routes(250);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_gains($urandom_range(65535), $urandom_range(65535),
                  $urandom_range(600), $urandom_range(6000));
        test_routes(250);
        set_gains(SPEED_GAIN_RST, TURN_GAIN_RST, ARRIVE_RAD_RST, HEAD_TOL_RST);
        test_routes(100);

        wait (exp_rd_idx == exp_wr_idx);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && exp_rd_idx == exp_wr_idx)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/wfc_pkg.sv
src/wfc_ram.sv
src/wfc_datapath.sv
src/wfc_ctrl.sv
src/waypoint_follow_controller.sv
sim/waypoint_follow_controller_tb.sv
